### hw/rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 adjugate matrix inverse
// Word layouts, arithmetic widths and the cofactor index tables.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int IW     = 16;          // input element width, Q8.8
   localparam int OW     = 32;          // output element width, Q16.16
   localparam int IN_FRAC  = 8;
   localparam int OUT_FRAC = 16;
   localparam int SH     = IN_FRAC + OUT_FRAC;   // numerator alignment shift
   localparam int PW     = 2 * IW;      // 2x2 product width
   localparam int CW     = 2 * IW + 1;  // cofactor width
   localparam int PDW    = IW + CW;     // determinant term width
   localparam int DW     = 3 * IW + 3;  // determinant width
   localparam int NW     = CW + SH;     // aligned numerator width
   localparam int SW     = $clog2(OW);  // divide step counter width
   localparam int QDEPTH = 4;           // job queue depth
   localparam int QAW    = $clog2(QDEPTH);

   typedef logic [3:0] idx_type;
   typedef logic signed [CW-1:0] cof_type;

   // Cofactor i (row-major) is m[A]*m[B] - m[C]*m[D], sign already folded in.
   localparam idx_type COF_A [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
   localparam idx_type COF_B [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
   localparam idx_type COF_C [9] = '{4'd7, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
   localparam idx_type COF_D [9] = '{4'd5, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};
   // Output element i takes the transposed cofactor.
   localparam idx_type TRANS [9] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

   typedef struct packed {
      logic signed [IW-1:0] in_r0c0;
      logic signed [IW-1:0] in_r0c1;
      logic signed [IW-1:0] in_r0c2;
      logic signed [IW-1:0] in_r1c0;
      logic signed [IW-1:0] in_r1c1;
      logic signed [IW-1:0] in_r1c2;
      logic signed [IW-1:0] in_r2c0;
      logic signed [IW-1:0] in_r2c1;
      logic signed [IW-1:0] in_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [OW-1:0] inv_r0c0;
      logic signed [OW-1:0] inv_r0c1;
      logic signed [OW-1:0] inv_r0c2;
      logic signed [OW-1:0] inv_r1c0;
      logic signed [OW-1:0] inv_r1c1;
      logic signed [OW-1:0] inv_r1c2;
      logic signed [OW-1:0] inv_r2c0;
      logic signed [OW-1:0] inv_r2c1;
      logic signed [OW-1:0] inv_r2c2;
      logic                 singular;
   } rsp_type;

   typedef struct packed {
      cof_type [8:0]        cof;
      logic signed [DW-1:0] det;
   } job_type;

endpackage

### hw/rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// Four registered stages: 2x2 products, cofactors, row 0 terms, determinant.
// ----------------------------------------------------------------------------
module mi3_front
   import mi3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    take,
   input  req_type req_data,
   output logic    push,
   output job_type job
);

   logic signed [IW-1:0]  m [9];
   logic [3:0]            v_ff;
   logic signed [PW-1:0]  pa_ff [9];
   logic signed [PW-1:0]  pb_ff [9];
   logic signed [IW-1:0]  m0_s1_ff [3];
   logic signed [IW-1:0]  m0_s2_ff [3];
   cof_type               cof_s2_ff [9];
   cof_type               cof_s3_ff [9];
   cof_type               cof_s4_ff [9];
   logic signed [PDW-1:0] dp_ff [3];
   logic signed [DW-1:0]  det_ff;

   assign m[0] = req_data.in_r0c0;
   assign m[1] = req_data.in_r0c1;
   assign m[2] = req_data.in_r0c2;
   assign m[3] = req_data.in_r1c0;
   assign m[4] = req_data.in_r1c1;
   assign m[5] = req_data.in_r1c2;
   assign m[6] = req_data.in_r2c0;
   assign m[7] = req_data.in_r2c1;
   assign m[8] = req_data.in_r2c2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         pa_ff[i]     <= PW'(m[COF_A[i]] * m[COF_B[i]]);
         pb_ff[i]     <= PW'(m[COF_C[i]] * m[COF_D[i]]);
         cof_s2_ff[i] <= CW'(pa_ff[i]) - CW'(pb_ff[i]);
         cof_s3_ff[i] <= cof_s2_ff[i];
         cof_s4_ff[i] <= cof_s3_ff[i];
      end
      for (int j = 0; j < 3; j++) begin
         m0_s1_ff[j] <= m[j];
         m0_s2_ff[j] <= m0_s1_ff[j];
         dp_ff[j]    <= PDW'(m0_s2_ff[j] * cof_s2_ff[j]);
      end
      det_ff <= DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);
   end

   assign push = v_ff[3];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         job.cof[i] = cof_s4_ff[i];
      end
      job.det = det_ff;
   end

endmodule

### hw/rtl/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue: small job queue between front and back
// Holds finished cofactor sets until the divider bank is free.
// ----------------------------------------------------------------------------
module mi3_queue
   import mi3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type head,
   output logic    empty
);

   job_type        entry_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff;
   logic [QAW-1:0] rd_ptr_ff;
   logic [QAW:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);

endmodule

### hw/rtl/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back: divider bank and result register
// Nine restoring dividers, one quotient bit per cycle, share one determinant.
// ----------------------------------------------------------------------------
module mi3_back
   import mi3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_head,
   output logic    pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [OW-1:0] HALF = OW'(1) << (OW - 1);

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [DW-1:0] d_ff, d_in;
   logic [DW-1:0] rem_ff [9];
   logic [DW-1:0] rem_in [9];
   logic [OW-1:0] num_ff [9];
   logic [OW-1:0] num_in [9];
   logic [OW-1:0] quo_ff [9];
   logic [OW-1:0] quo_in [9];
   logic          ov_ff [9];
   logic          ov_in [9];
   logic          neg_ff [9];
   logic          neg_in [9];
   logic          valid_ff, valid_in;
   rsp_type       data_ff, data_in;

   logic [CW-1:0] acof [9];
   logic [NW-1:0] anum [9];
   logic [DW-1:0] adet;
   logic [DW:0]   trial [9];
   logic [OW-1:0] res [9];

   // Magnitudes of the head job, used when it is loaded.
   always_comb begin
      adet = q_head.det[DW-1] ? DW'(-q_head.det) : DW'(q_head.det);
      for (int i = 0; i < 9; i++) begin
         acof[i] = q_head.cof[TRANS[i]][CW-1] ? CW'(-q_head.cof[TRANS[i]])
                                               : CW'(q_head.cof[TRANS[i]]);
         anum[i] = {acof[i], {SH{1'b0}}};
      end
   end

   // Saturated, signed quotients from the finished dividers.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         trial[i] = {rem_ff[i], num_ff[i][OW-1]};
         if (neg_ff[i]) begin
            res[i] = (ov_ff[i] || quo_ff[i] > HALF) ? HALF : (OW'(0) - quo_ff[i]);
         end else begin
            res[i] = (ov_ff[i] || quo_ff[i] > HALF - 1'b1) ? HALF - 1'b1 : quo_ff[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      d_in     = d_ff;
      valid_in = 1'b0;
      data_in  = data_ff;
      pop      = 1'b0;
      for (int i = 0; i < 9; i++) begin
         rem_in[i] = rem_ff[i];
         num_in[i] = num_ff[i];
         quo_in[i] = quo_ff[i];
         ov_in[i]  = ov_ff[i];
         neg_in[i] = neg_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               if (q_head.det == '0) begin
                  valid_in         = 1'b1;
                  data_in          = '0;
                  data_in.singular = 1'b1;
               end else begin
                  state_in = ST_RUN;
                  step_in  = '0;
                  d_in     = adet;
                  for (int i = 0; i < 9; i++) begin
                     rem_in[i] = DW'(anum[i][NW-1:OW]);
                     num_in[i] = anum[i][OW-1:0];
                     quo_in[i] = '0;
                     ov_in[i]  = DW'(anum[i][NW-1:OW]) >= adet;
                     neg_in[i] = q_head.cof[TRANS[i]][CW-1] ^ q_head.det[DW-1];
                  end
               end
            end
         end
         ST_RUN: begin
            for (int i = 0; i < 9; i++) begin
               if (trial[i] >= {1'b0, d_ff}) begin
                  rem_in[i] = DW'(trial[i] - {1'b0, d_ff});
                  quo_in[i] = {quo_ff[i][OW-2:0], 1'b1};
               end else begin
                  rem_in[i] = trial[i][DW-1:0];
                  quo_in[i] = {quo_ff[i][OW-2:0], 1'b0};
               end
               num_in[i] = num_ff[i] << 1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(OW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            valid_in         = 1'b1;
            data_in.inv_r0c0 = res[0];
            data_in.inv_r0c1 = res[1];
            data_in.inv_r0c2 = res[2];
            data_in.inv_r1c0 = res[3];
            data_in.inv_r1c1 = res[4];
            data_in.inv_r1c2 = res[5];
            data_in.inv_r2c0 = res[6];
            data_in.inv_r2c1 = res[7];
            data_in.inv_r2c2 = res[8];
            data_in.singular = 1'b0;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      d_ff    <= d_in;
      data_ff <= data_in;
      for (int i = 0; i < 9; i++) begin
         rem_ff[i] <= rem_in[i];
         num_ff[i] <= num_in[i];
         quo_ff[i] <= quo_in[i];
         ov_ff[i]  <= ov_in[i];
         neg_ff[i] <= neg_in[i];
      end
   end

   assign rsp_strobe = valid_ff;
   assign rsp_data   = data_ff;

endmodule

### hw/rtl/matrix3_inverse_adjugate_top.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate_top: 3x3 matrix inverse by the adjugate
// Signed Q8.8 matrix in, signed Q16.16 saturated inverse and singular flag out.
// ----------------------------------------------------------------------------
// How to use this block:
// A matrix word (nine Q8.8 elements, row-major, on req_data) is taken at a
// rising clock edge where start is high and busy is low. Each taken word gives
// exactly one result word on rsp_data, marked by rsp_strobe for one cycle;
// the receiver must take it then, since there is no way to hold it off.
// The front pipeline forms cofactors and the determinant in registered stages
// (products, cofactors, row 0 terms, determinant) and drops the job into a
// four-entry queue, so new words are taken back to back while the back end is
// working. Busy rises once four jobs are in flight. The back end runs nine
// restoring dividers in parallel, one quotient bit per cycle; a regular matrix
// passes through load, 32 divide steps and finish, while a singular one is
// answered from the idle state without dividing. The shared divider bank
// takes the next queued job only after the last one has finished, which sets
// the sustained throughput. Synchronous reset empties the pipeline and the
// queue and drops any result not yet shown.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate_top
   import mi3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic           take;
   logic           push;
   logic           pop;
   logic           q_empty;
   job_type        job;
   job_type        q_head;
   logic [QAW:0]   occ_ff;

   // Jobs in the front pipeline plus jobs in the queue never exceed the
   // queue depth, so the front never has to stall.
   assign busy = (occ_ff == (QAW + 1)'(QDEPTH));
   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (take && !pop) begin
         occ_ff <= occ_ff + 1'b1;
      end else if (pop && !take) begin
         occ_ff <= occ_ff - 1'b1;
      end
   end

   mi3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .push     (push),
      .job      (job)
   );

   mi3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (job),
      .pop       (pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   mi3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
